/* sv/hci_pkg.sv */
// ----------------------------------------------------------------------------
// hci_pkg
// Shared types, constants and small tables of the hex cell quad indexer.
// ----------------------------------------------------------------------------
package hci_pkg;

   // fixed point format of the plane coordinates
   localparam int COORD_FRAC_BITS = 28;
   localparam int MAX_RESOLUTION  = 15;

   // floor(2^30 / sqrt(3)), 30 bits
   localparam logic [30:0] SQRT3_RECIP = 31'd619925131;

   // working widths
   localparam int VW = 54;                    // binned coordinate products
   localparam int WW = VW - COORD_FRAC_BITS;  // coordinate after the fraction shift
   localparam int RW = 28;                    // rounded hex coordinates
   localparam int EW = RW + COORD_FRAC_BITS + 1;  // rounding error

   localparam logic signed [VW-1:0] HALF_DEN = VW'(64'd3 << (COORD_FRAC_BITS - 1));
   // offset that keeps the value positive for the divide by three
   localparam logic signed [WW+1:0] DIV3_OFF = (WW+2)'(64'd3 << (WW - 1));
   localparam logic signed [RW-1:0] DIV3_OFF_Q = RW'(64'd1 << (WW - 1));
   localparam logic [31:0] DIV3_MUL = 32'hAAAAAAAB;

   // index and serial limits
   localparam logic signed [RW-1:0] IDX_HI = RW'(65536);
   localparam logic signed [RW-1:0] IDX_LO = -RW'(65536);
   localparam logic [33:0] SERIAL_MAX = 34'd10737418242;

   // quad codes
   localparam logic [3:0] QUAD_NORTH = 4'd0;
   localparam logic [3:0] QUAD_SOUTH = 4'd11;

   // register byte address bit: 0 aperture, 1 resolution
   localparam logic REG_APERTURE   = 1'b0;
   localparam logic REG_RESOLUTION = 1'b1;

   // grid figures derived from the configuration
   typedef struct packed {
      logic        odd;     // aperture 3 with odd resolution
      logic [15:0] side;    // side length in hexes
      logic [16:0] maxc;    // max coordinate, odd case
      logic [30:0] hexes;   // hexes per quad
      logic [11:0] h;       // odd case divisor
      logic [32:0] recip;   // ceil(2^32 / h)
   } hci_grid_type;

   // powers of three
   function automatic logic [23:0] pow3(input logic [3:0] n);
      logic [23:0] p;
      case (n)
         4'd0:    p = 24'd1;
         4'd1:    p = 24'd3;
         4'd2:    p = 24'd9;
         4'd3:    p = 24'd27;
         4'd4:    p = 24'd81;
         4'd5:    p = 24'd243;
         4'd6:    p = 24'd729;
         4'd7:    p = 24'd2187;
         4'd8:    p = 24'd6561;
         4'd9:    p = 24'd19683;
         4'd10:   p = 24'd59049;
         4'd11:   p = 24'd177147;
         4'd12:   p = 24'd531441;
         4'd13:   p = 24'd1594323;
         4'd14:   p = 24'd4782969;
         default: p = 24'd14348907;
      endcase
      return p;
   endfunction

   // ceil(2^32 / 3^k)
   function automatic logic [32:0] recip3(input logic [2:0] k);
      logic [32:0] m;
      case (k)
         3'd0:    m = 33'd4294967296;
         3'd1:    m = 33'd1431655766;
         3'd2:    m = 33'd477218589;
         3'd3:    m = 33'd159072863;
         3'd4:    m = 33'd53024288;
         3'd5:    m = 33'd17674763;
         3'd6:    m = 33'd5891588;
         default: m = 33'd1963863;
      endcase
      return m;
   endfunction

endpackage

/* sv/hci_serial.sv */
// ----------------------------------------------------------------------------
// hci_serial
// Serial number of a cell: products in one stage, sum and saturation in the
// next, which also forms the result registers.
// ----------------------------------------------------------------------------
module hci_serial (
   input  logic                      clock,
   input  logic                      reset,
   input  hci_pkg::hci_grid_type     grid,
   input  logic                      in_valid,
   input  logic [3:0]                in_quad,
   input  logic signed [17:0]        in_d,
   input  logic signed [17:0]        in_i,
   output logic                      out_valid,
   output logic [3:0]                out_quad,
   output logic signed [17:0]        out_d,
   output logic signed [17:0]        out_i,
   output logic [33:0]               out_serial
);
   import hci_pkg::*;

   logic                valid_ff;
   logic [3:0]          quad_ff;
   logic signed [17:0]  d_ff, i_ff;
   logic                north_ff, ineg_ff;
   logic signed [30:0]  dh_ff, dh_in;
   logic signed [34:0]  sd_ff, sd_in;
   logic [34:0]         qh_ff, qh_in;
   logic [49:0]         iq_ff, iq_in;
   logic [16:0]         iabs;
   logic [3:0]          qm1;

   logic                ovalid_ff;
   logic [3:0]          oquad_ff;
   logic signed [17:0]  od_ff, oi_ff;
   logic [33:0]         serial_ff, serial_in;
   logic signed [17:0]  iq_t;
   logic signed [39:0]  sum;

   // product stage
   always_comb begin
      iabs  = in_i[17] ? 17'(-in_i) : in_i[16:0];
      qm1   = (in_quad == QUAD_NORTH) ? 4'd0 : in_quad - 4'd1;
      dh_in = 31'(in_d * $signed({1'b0, grid.h}));
      sd_in = 35'(in_d * $signed({1'b0, grid.side}));
      qh_in = 35'(qm1) * 35'(grid.hexes);
      iq_in = 50'(iabs) * 50'(grid.recip);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      quad_ff  <= in_quad;
      d_ff     <= in_d;
      i_ff     <= in_i;
      north_ff <= (in_quad == QUAD_NORTH);
      ineg_ff  <= in_i[17];
      dh_ff    <= dh_in;
      sd_ff    <= sd_in;
      qh_ff    <= qh_in;
      iq_ff    <= iq_in;
   end

   // sum and saturation stage
   always_comb begin
      iq_t = ineg_ff ? -$signed({1'b0, iq_ff[48:32]}) : $signed({1'b0, iq_ff[48:32]});
      if (grid.odd) begin
         sum = 40'(dh_ff) + 40'(iq_t) + $signed({5'd0, qh_ff}) + 40'sd2;
      end else begin
         sum = $signed({5'd0, qh_ff}) + 40'(sd_ff) + 40'(i_ff) + 40'sd2;
      end
      if (north_ff) begin
         serial_in = 34'd1;
      end else if (sum < 40'sd0) begin
         serial_in = 34'd0;
      end else if (sum > $signed({6'd0, SERIAL_MAX})) begin
         serial_in = SERIAL_MAX;
      end else begin
         serial_in = sum[33:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else begin
         ovalid_ff <= valid_ff;
      end
      oquad_ff  <= quad_ff;
      od_ff     <= d_ff;
      oi_ff     <= i_ff;
      serial_ff <= serial_in;
   end

   assign out_valid  = ovalid_ff;
   assign out_quad   = oquad_ff;
   assign out_d      = od_ff;
   assign out_i      = oi_ff;
   assign out_serial = serial_ff;

endmodule

/* sv/hex_cell_quad_index.sv */
// ----------------------------------------------------------------------------
// hex_cell_quad_index
// Bins a quad plane point to a hex cell, remaps shared edges and poles and
// gives the cell's d/i indices and global serial.
// ----------------------------------------------------------------------------
// throughput: one point per cycle, busy is never raised
// the depth is set by the binning multipliers, the divide by three and the
// serial products, each in a stage of its own
// reset clears the pipeline valid bits and loads aperture 3, resolution 4
module hex_cell_quad_index (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [3:0]          req_quad_in,
   input  logic signed [31:0]  req_x_pos,
   input  logic signed [31:0]  req_y_pos,
   output logic                rsp_valid,
   output logic [3:0]          rsp_quad_out,
   output logic signed [17:0]  rsp_d_index,
   output logic signed [17:0]  rsp_i_index,
   output logic [33:0]         rsp_serial,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import hci_pkg::*;

   localparam int F = COORD_FRAC_BITS;

   // configuration registers
   logic [2:0] aperture_ff;
   logic [3:0] resolution_ff;
   logic       ap3, cfg_wr;
   logic [3:0] res;
   hci_grid_type grid;

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         aperture_ff   <= 3'd3;
         resolution_ff <= 4'd4;
      end else if (cfg_wr) begin
         case (paddr[2])
            REG_APERTURE:   aperture_ff   <= pwdata[2:0];
            REG_RESOLUTION: resolution_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   assign prdata = (paddr[2] == REG_RESOLUTION) ? {28'd0, resolution_ff} : {29'd0, aperture_ff};

   // grid figures
   always_comb begin
      res        = (resolution_ff > 4'(MAX_RESOLUTION)) ? 4'(MAX_RESOLUTION) : resolution_ff;
      ap3        = (aperture_ff == 3'd3);
      grid.odd   = ap3 && res[0];
      grid.side  = ap3 ? 16'(pow3({1'b0, res[3:1]})) : 16'(17'd1 << res);
      grid.maxc  = 17'(17'd1 << res) + 17'd1;
      grid.hexes = ap3 ? 31'(pow3(res)) : 31'(31'd1 << {res, 1'b0});
      grid.h     = 12'(pow3({1'b0, 3'((res - 4'd1) >> 1)}));
      grid.recip = recip3(3'((res - 4'd1) >> 1));
   end

   logic [8:0] vld_ff;
   logic [3:0] q_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[7:0], start && !busy};
      end
   end

   // stage 1: y / sqrt(3), quad clamp
   logic signed [62:0] yprod;
   logic signed [31:0] yk_ff, x1_ff;
   logic [3:0]         quad_in;

   always_comb begin
      yprod = 63'(req_y_pos * $signed(SQRT3_RECIP));
      if (req_quad_in == 4'd0)       quad_in = 4'd1;
      else if (req_quad_in > 4'd10)  quad_in = 4'd10;
      else                           quad_in = req_quad_in;
   end

   always_ff @(posedge clock) begin
      yk_ff   <= yprod[61:30];
      x1_ff   <= req_x_pos;
      q_ff[0] <= quad_in;
   end

   // stage 2: multiplier operands
   logic signed [34:0] ax_ff, ay_ff, ax_in, ay_in, x35, yk35;
   logic [17:0]        cx_ff, cy_ff, cx_in, cy_in;

   always_comb begin
      x35  = 35'(x1_ff);
      yk35 = 35'(yk_ff);
      if (grid.odd) begin
         ax_in = x35;
         ay_in = 35'sd3 * yk35 - x35;
         cx_in = {grid.maxc, 1'b0};
         cy_in = {1'b0, grid.maxc};
      end else begin
         ax_in = x35 + yk35;
         ay_in = yk35 - x35;
         cx_in = 18'(grid.side) * 18'd3;
         cy_in = 18'(grid.side) * 18'd3;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      q_ff[1] <= q_ff[0];
   end

   // stage 3: scaled cube coordinates
   logic signed [VW-1:0] vx_ff, vy_ff;

   always_ff @(posedge clock) begin
      vx_ff   <= VW'(ax_ff * $signed({1'b0, cx_ff}));
      vy_ff   <= VW'(ay_ff * $signed({1'b0, cy_ff}));
      q_ff[2] <= q_ff[1];
   end

   // stage 4: third coordinate, add half and drop the fraction
   logic signed [VW-1:0] v4_in [3];
   logic signed [VW-1:0] v4_ff [3];
   logic signed [VW-1:0] hsum [3];
   logic signed [WW-1:0] w_ff [3];

   always_comb begin
      v4_in[0] = vx_ff;
      v4_in[1] = vy_ff;
      v4_in[2] = -vx_ff - vy_ff;
      for (int k = 0; k < 3; k++) begin
         hsum[k] = v4_in[k] + HALF_DEN;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         v4_ff[k] <= v4_in[k];
         w_ff[k]  <= $signed(hsum[k][VW-1:F]);
      end
      q_ff[3] <= q_ff[2];
   end

   // stage 5: floor divide by three through the reciprocal
   logic signed [WW+1:0] ud [3];
   logic [58:0]          dprod [3];
   logic signed [RW-1:0] r5_ff [3];
   logic signed [VW-1:0] v5_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ud[k]    = (WW+2)'(w_ff[k]) + DIV3_OFF;
         dprod[k] = 59'(ud[k][26:0]) * 59'(DIV3_MUL);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         r5_ff[k] <= $signed(RW'(dprod[k][58:33])) - DIV3_OFF_Q;
         v5_ff[k] <= v4_ff[k];
      end
      q_ff[4] <= q_ff[3];
   end

   // stage 6: coordinate sum and rounding errors
   logic signed [EW-1:0] ediff [3];
   logic signed [RW-1:0] r3 [3];
   logic [EW-1:0]        e_ff [3];
   logic signed [RW-1:0] r6_ff [3];
   logic signed [RW-1:0] s_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         r3[k]    = r5_ff[k] * RW'(3);
         ediff[k] = $signed({r3[k][RW-1], r3[k], {F{1'b0}}}) - EW'(v5_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         r6_ff[k] <= r5_ff[k];
         e_ff[k]  <= ediff[k][EW-1] ? EW'(-ediff[k]) : EW'(ediff[k]);
      end
      s_ff    <= r5_ff[0] + r5_ff[1] + r5_ff[2];
      q_ff[5] <= q_ff[4];
   end

   // stage 7: the coordinate with the largest error takes up the sum
   logic signed [RW-1:0] r7_in [3];
   logic signed [RW-1:0] r7_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) r7_in[k] = r6_ff[k];
      if (s_ff != '0) begin
         if (e_ff[0] >= e_ff[1] && e_ff[0] >= e_ff[2])      r7_in[0] = r6_ff[0] - s_ff;
         else if (e_ff[1] >= e_ff[0] && e_ff[1] >= e_ff[2]) r7_in[1] = r6_ff[1] - s_ff;
         else                                               r7_in[2] = r6_ff[2] - s_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) r7_ff[k] <= r7_in[k];
      q_ff[6] <= q_ff[5];
   end

   // stage 8: d/i indices and edge remap
   logic signed [RW-1:0] d8_in, i8_in, d8_ff, i8_ff, hx, hy, hz, mc, sd;
   logic [3:0]           q8_in, qc;

   always_comb begin
      qc = q_ff[6];
      q8_in = qc;
      mc = RW'(grid.maxc);
      sd = RW'(grid.side);
      hx = r7_ff[0];
      hy = r7_ff[1];
      hz = r7_ff[2];
      d8_in = '0;
      i8_in = '0;
      if (grid.odd) begin
         d8_in = hx - hz;
         i8_in = hx + (hy <<< 1);
         if (qc <= 4'd5) begin
            if (d8_in == '0 && i8_in == mc) begin
               q8_in = QUAD_NORTH; d8_in = '0; i8_in = '0;
            end else if (i8_in == mc) begin
               q8_in = (qc == 4'd5) ? 4'd1 : qc + 4'd1;
               i8_in = mc - d8_in; d8_in = '0;
            end else if (d8_in == mc) begin
               q8_in = qc + 4'd5; d8_in = '0;
            end
         end else begin
            if (i8_in == '0 && d8_in == mc) begin
               q8_in = QUAD_SOUTH; d8_in = '0; i8_in = '0;
            end else if (d8_in == mc) begin
               q8_in = (qc == 4'd10) ? 4'd6 : qc + 4'd1;
               d8_in = mc - i8_in; i8_in = '0;
            end else if (i8_in == mc) begin
               q8_in = (qc == 4'd10) ? 4'd1 : qc - 4'd4; i8_in = '0;
            end
         end
      end else begin
         if (qc <= 4'd5) begin
            if (hx == '0 && hz == -sd) begin
               q8_in = QUAD_NORTH; hx = '0; hy = '0; hz = '0;
            end else if (hz == -sd) begin
               q8_in = (qc == 4'd5) ? 4'd1 : qc + 4'd1;
               hy = sd - hx; hz = hx - sd; hx = '0;
            end else if (hx == sd) begin
               q8_in = qc + 4'd5; hy = -hz; hx = '0;
            end
         end else begin
            if (hz == '0 && hx == sd) begin
               q8_in = QUAD_SOUTH; hx = '0; hy = '0; hz = '0;
            end else if (hx == sd) begin
               q8_in = (qc == 4'd10) ? 4'd6 : qc + 4'd1;
               hx = hy + sd; hy = '0; hz = -hx;
            end else if (hy == -sd) begin
               q8_in = (qc == 4'd10) ? 4'd1 : qc - 4'd4;
               hy = '0; hz = -hx;
            end
         end
         d8_in = hx;
         i8_in = -hz;
      end
   end

   always_ff @(posedge clock) begin
      d8_ff   <= d8_in;
      i8_ff   <= i8_in;
      q_ff[7] <= q8_in;
   end

   // stage 9: index saturation
   logic signed [17:0] d9_ff, i9_ff;

   always_ff @(posedge clock) begin
      d9_ff   <= (d8_ff > IDX_HI) ? IDX_HI[17:0] : (d8_ff < IDX_LO) ? IDX_LO[17:0] : d8_ff[17:0];
      i9_ff   <= (i8_ff > IDX_HI) ? IDX_HI[17:0] : (i8_ff < IDX_LO) ? IDX_LO[17:0] : i8_ff[17:0];
      q_ff[8] <= q_ff[7];
   end

   // serial number and result registers
   hci_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .grid       (grid),
      .in_valid   (vld_ff[8]),
      .in_quad    (q_ff[8]),
      .in_d       (d9_ff),
      .in_i       (i9_ff),
      .out_valid  (rsp_valid),
      .out_quad   (rsp_quad_out),
      .out_d      (rsp_d_index),
      .out_i      (rsp_i_index),
      .out_serial (rsp_serial)
   );

   // checks
   a_lat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 11)) else $error("result without a transfer");
   a_pole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_quad_out == QUAD_NORTH || rsp_quad_out == QUAD_SOUTH)
      |-> rsp_d_index == '0 && rsp_i_index == '0) else $error("pole indices not zero");
   a_north: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_quad_out == QUAD_NORTH |-> rsp_serial == 34'd1)
      else $error("north pole serial wrong");
   a_quad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quad_out <= QUAD_SOUTH) else $error("quad out of range");

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// hex cell quad index testbench
// Drives plane points through the hex cell indexer under several grid
// settings and compares every cell transfer against an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import hci_pkg::*;

   typedef struct {
      logic [3:0]         quad;
      logic signed [17:0] d;
      logic signed [17:0] i;
      logic [33:0]        serial;
   } cell_type;

   localparam int WATCHDOG = 4000;
   localparam int LATENCY  = 11;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [3:0]         req_quad_in = '0;
   logic signed [31:0] req_x_pos = '0;
   logic signed [31:0] req_y_pos = '0;
   logic               rsp_valid;
   logic [3:0]         rsp_quad_out;
   logic signed [17:0] rsp_d_index;
   logic signed [17:0] rsp_i_index;
   logic [33:0]        rsp_serial;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   // predictor copy of the registers
   logic [2:0] grid_aperture = 3'd3;
   logic [3:0] grid_resolution = 4'd4;

   cell_type expected_cells[$];
   int mismatches = 0;
   int idle_cycles = 0;

   hex_cell_quad_index uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_quad_in(req_quad_in), .req_x_pos(req_x_pos), .req_y_pos(req_y_pos),
      .rsp_valid(rsp_valid), .rsp_quad_out(rsp_quad_out),
      .rsp_d_index(rsp_d_index), .rsp_i_index(rsp_i_index),
      .rsp_serial(rsp_serial), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready)
   );

   always #4 clock = ~clock;

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint power3(int n);
      longint p;
      p = 1;
      for (int k = 0; k < n; k++) p *= 3;
      return p;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // bins one point to its cell under the current grid setting
   function automatic cell_type bin_point(logic [3:0] qin, logic signed [31:0] xin,
                                          logic signed [31:0] yin);
      cell_type c;
      longint q, x, y, yk, den, half, side, maxc, vx, vy, vz, rx, ry, rz, s;
      longint ex, ey, ez, d, i, hx, hy, hz, hexes, sn, h;
      int res;
      bit ap3, odd;
      q = qin; x = xin; y = yin;
      res = grid_resolution > MAX_RESOLUTION ? MAX_RESOLUTION : grid_resolution;
      ap3 = (grid_aperture == 3'd3);
      odd = ap3 && res[0];
      yk = floor_div(y * 64'sd619925131, 64'sd1 << 30);
      den = 3 * (64'sd1 << COORD_FRAC_BITS);
      half = den / 2;
      side = 0; maxc = 0;
      if (q < 1) q = 1;
      if (q > 10) q = 10;
      if (odd) begin
         maxc = (64'sd1 << res) + 1;
         vx = 2 * maxc * x;
         vy = maxc * (3 * yk - x);
      end else begin
         side = ap3 ? power3(res / 2) : (64'sd1 << res);
         vx = 3 * side * (x + yk);
         vy = 3 * side * (yk - x);
      end
      vz = -vx - vy;
      rx = floor_div(vx + half, den);
      ry = floor_div(vy + half, den);
      rz = floor_div(vz + half, den);
      s = rx + ry + rz;
      // the coordinate with the largest rounding error takes up the sum
      if (s != 0) begin
         ex = rx * den - vx; if (ex < 0) ex = -ex;
         ey = ry * den - vy; if (ey < 0) ey = -ey;
         ez = rz * den - vz; if (ez < 0) ez = -ez;
         if (ex >= ey && ex >= ez) rx -= s;
         else if (ey >= ex && ey >= ez) ry -= s;
         else rz -= s;
      end
      if (odd) begin
         d = rx - rz;
         i = rx + 2 * ry;
         if (q <= 5) begin
            if (d == 0 && i == maxc) begin q = 0; d = 0; i = 0; end
            else if (i == maxc) begin q = (q == 5) ? 1 : q + 1; i = maxc - d; d = 0; end
            else if (d == maxc) begin q += 5; d = 0; end
         end else begin
            if (i == 0 && d == maxc) begin q = 11; d = 0; i = 0; end
            else if (d == maxc) begin q = (q == 10) ? 6 : q + 1; d = maxc - i; i = 0; end
            else if (i == maxc) begin q = (q == 10) ? 1 : q - 4; i = 0; end
         end
      end else begin
         hx = rx; hy = ry; hz = rz;
         if (q <= 5) begin
            if (hx == 0 && hz == -side) begin q = 0; hx = 0; hy = 0; hz = 0; end
            else if (hz == -side) begin
               q = (q == 5) ? 1 : q + 1;
               hy = side - hx; hz = hx - side; hx = 0;
            end else if (hx == side) begin q += 5; hy = -hz; hx = 0; end
         end else begin
            if (hz == 0 && hx == side) begin q = 11; hx = 0; hy = 0; hz = 0; end
            else if (hx == side) begin
               q = (q == 10) ? 6 : q + 1;
               hx = hy + side; hy = 0; hz = -hx;
            end else if (hy == -side) begin
               q = (q == 10) ? 1 : q - 4;
               hy = 0; hz = -hx;
            end
         end
         d = hx;
         i = -hz;
      end
      d = clamp(d, -65536, 65536);
      i = clamp(i, -65536, 65536);
      hexes = ap3 ? power3(res) : (64'sd1 << (2 * res));
      if (q == 0) sn = 1;
      else if (q == 11) sn = 10 * hexes + 2;
      else if (odd) begin
         h = power3((res - 1) / 2);
         sn = d * h + i / h + (q - 1) * hexes + 2;
      end else begin
         sn = (q - 1) * hexes + side * d + i + 2;
      end
      sn = clamp(sn, 0, 64'sd10737418242);
      c.quad = q[3:0];
      c.d = d[17:0];
      c.i = i[17:0];
      c.serial = sn[33:0];
      return c;
   endfunction

   // compare each cell transfer with the oldest prediction
   always @(posedge clock) begin
      cell_type e;
      if (!reset && rsp_valid) begin
         if (expected_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected cell transfer q=%0d", rsp_quad_out);
         end else begin
            e = expected_cells.pop_front();
            if (e.quad !== rsp_quad_out || e.d !== rsp_d_index ||
                e.i !== rsp_i_index || e.serial !== rsp_serial) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("cell mismatch: exp q=%0d d=%0d i=%0d s=%0d got q=%0d d=%0d i=%0d s=%0d",
                           e.quad, e.d, e.i, e.serial, rsp_quad_out, rsp_d_index,
                           rsp_i_index, rsp_serial);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("tb: failure");
         $finish;
      end
   end

   // start stays high between back to back transfers
   task automatic send_point(logic [3:0] q, logic [31:0] x, logic [31:0] y, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_quad_in <= q;
      req_x_pos <= x;
      req_y_pos <= y;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_cells.push_back(bin_point(q, x, y));
   endtask

   task automatic drain_cells();
      start <= 1'b0;
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] addr, logic [31:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == 3'd0) grid_aperture = value[2:0];
      else if (addr == 3'd4) grid_resolution = value[3:0];
      @(posedge clock);
   endtask

   task automatic set_grid(logic [31:0] ap, logic [31:0] res);
      drain_cells();
      write_reg(3'd0, ap);
      write_reg(3'd4, res);
   endtask

   // random coordinates at mixed scales, some near multiples of 2^24, to reach the remap paths
   function automatic logic [31:0] near_cell();
      int sel;
      sel = $urandom_range(0, 3);
      if (sel == 0) return $urandom;
      if (sel == 1) return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
      if (sel == 2) return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      return 32'(($urandom_range(0, 64) - 32) * 32'h0100_0000 + $urandom_range(0, 255) - 128);
   endfunction

   task automatic test_directed();
      logic [31:0] vals[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                               32'h1000_0000, 32'hf000_0000};
      for (int k = 0; k < 16; k++)
         send_point(4'(k), vals[k % 6], vals[(k + 1) % 6], 0);
      send_point(4'd5, 32'h0, 32'h0, 0);
      send_point(4'd10, 32'h7fff_ffff, 32'h7fff_ffff, 0);
   endtask

   task automatic test_random(int count);
      for (int k = 0; k < count; k++)
         send_point(4'($urandom_range(0, 15)), near_cell(), near_cell(),
                    ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
   endtask

   task automatic test_grids();
      logic [31:0] aps[4] = '{32'd3, 32'd4, 32'd3, 32'hffff_fff8};
      for (int g = 0; g < 16; g++) begin
         set_grid(aps[g % 4], (g == 15) ? 32'hffff_ffff : 32'(g));
         test_random(66);
      end
      // sender holds off until every cell has come back
      drain_cells();
      set_grid(32'd4, 32'd1);
      test_random(60);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(40);
      set_grid(32'd4, 32'd15);
      test_directed();
      set_grid(32'd3, 32'd0);
      test_directed();
      test_grids();
      drain_cells();
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

/* sim.f */
sv/hci_pkg.sv
sv/hci_serial.sv
sv/hex_cell_quad_index.sv
tb/sv/testbench.sv
